// File: rtl/lzfb_pkg.sv
// shared constants, types and helpers for the local zenith frame block
package lzfb_pkg;
  localparam int FRAC_BITS = 16;
  localparam int W = 18;
  localparam int RAD_W = 2 * FRAC_BITS + 4;
  localparam int S_W = RAD_W / 2;
  localparam int NUM_W = W + FRAC_BITS + 1;
  localparam int Q_W = NUM_W;
  localparam int NDIV = Q_W;
  localparam int NSQ = S_W;
  localparam int SQ_PER = 2;
  localparam int DV_PER = 2;
  localparam int NSQ_ST = (NSQ + SQ_PER - 1) / SQ_PER;
  localparam int NDV_ST = (NDIV + DV_PER - 1) / DV_PER;
  localparam logic [W-1:0] ONE = W'(1 << FRAC_BITS);
  localparam logic [RAD_W-1:0] ONE2 = RAD_W'(64'd1 << (2 * FRAC_BITS));
  localparam logic [RAD_W-1:0] THR =
    RAD_W'(((64'd1 << (2 * FRAC_BITS)) + 64'd39999) / 64'd40000);
  localparam logic [3:0] SLOTS_OK = 4'd3;
  localparam logic signed [W-1:0] S_MAX = W'((1 << (W - 1)) - 1);
  localparam logic signed [W-1:0] S_MIN = W'(1 << (W - 1));

  typedef logic signed [W-1:0] comp_t;

  typedef struct packed {
    logic ok;
    logic axis;
    logic zneg;
    comp_t x;
    comp_t y;
    comp_t z;
  } ctl_t;

  function automatic comp_t sat(input logic signed [63:0] v);
    if (v > 64'(S_MAX)) return S_MAX;
    if (v < 64'(S_MIN)) return S_MIN;
    return v[W-1:0];
  endfunction

  // round to nearest, ties away from zero, by 2^FRAC_BITS
  function automatic logic signed [63:0] rnd_sh(input logic signed [63:0] v);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    m = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction
endpackage

// File: rtl/lzfb_sqrt.sv
// pipelined integer square root of the clamped radicand, two bits per stage
module lzfb_sqrt (
  input  logic clk,
  input  logic en,
  input  logic [lzfb_pkg::RAD_W-1:0] rad,
  input  lzfb_pkg::ctl_t ctl_in,
  output logic [lzfb_pkg::S_W-1:0] root,
  output lzfb_pkg::ctl_t ctl_out
);
  import lzfb_pkg::*;
  logic [RAD_W-1:0] rem [NSQ_ST+1];
  logic [S_W-1:0] res [NSQ_ST+1];
  logic [RAD_W-1:0] src [NSQ_ST+1];
  ctl_t c [NSQ_ST+1];

  always_comb begin
    rem[0] = '0;
    res[0] = '0;
    src[0] = rad;
    c[0] = ctl_in;
  end

  for (genvar g = 0; g < NSQ_ST; g++) begin : g_st
    logic [RAD_W-1:0] r_n, s_n;
    logic [S_W-1:0] q_n;
    always_comb begin
      logic [RAD_W+1:0] t;
      r_n = rem[g];
      q_n = res[g];
      s_n = src[g];
      for (int k = 0; k < SQ_PER; k++) begin
        if (g * SQ_PER + k < NSQ) begin
          r_n = {r_n[RAD_W-3:0], s_n[RAD_W-1 -: 2]};
          s_n = {s_n[RAD_W-3:0], 2'b00};
          t = {2'b00, r_n} - {(RAD_W + 2 - S_W - 2)'(0), q_n, 2'b01};
          if (!t[RAD_W+1]) begin
            r_n = t[RAD_W-1:0];
            q_n = {q_n[S_W-2:0], 1'b1};
          end else begin
            q_n = {q_n[S_W-2:0], 1'b0};
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[g+1] <= r_n;
        res[g+1] <= q_n;
        src[g+1] <= s_n;
        c[g+1] <= c[g];
      end
    end
  end

  assign root = res[NSQ_ST];
  assign ctl_out = c[NSQ_ST];
endmodule

// File: rtl/lzfb_div.sv
// two pipelined restoring dividers for the west components, two bits per stage
module lzfb_div (
  input  logic clk,
  input  logic en,
  input  logic [lzfb_pkg::S_W-1:0] den,
  input  lzfb_pkg::ctl_t ctl_in,
  output logic signed [lzfb_pkg::Q_W:0] wx,
  output logic signed [lzfb_pkg::Q_W:0] wy,
  output lzfb_pkg::ctl_t ctl_out
);
  import lzfb_pkg::*;
  localparam int R_W = S_W + 1;
  logic [NUM_W-1:0] na [NDV_ST+1], nb [NDV_ST+1];
  logic [R_W-1:0] ra [NDV_ST+1], rb [NDV_ST+1];
  logic [S_W-1:0] d [NDV_ST+1];
  ctl_t c [NDV_ST+1];
  logic [NUM_W-1:0] mx, my;
  logic sx, sy, sxo, syo;

  always_comb begin
    logic signed [NUM_W-1:0] vy, vx;
    vy = NUM_W'(ctl_in.y) <<< FRAC_BITS;
    vx = -(NUM_W'(ctl_in.x) <<< FRAC_BITS);
    sx = vy[NUM_W-1];
    sy = vx[NUM_W-1];
    // magnitudes are divided, the sign is restored after rounding
    mx = sx ? NUM_W'(-vy) : NUM_W'(vy);
    my = sy ? NUM_W'(-vx) : NUM_W'(vx);
    na[0] = mx;
    nb[0] = my;
    ra[0] = '0;
    rb[0] = '0;
    d[0] = den;
    c[0] = ctl_in;
  end

  logic sgx [NDV_ST+1], sgy [NDV_ST+1];
  assign sgx[0] = sx;
  assign sgy[0] = sy;

  for (genvar g = 0; g < NDV_ST; g++) begin : g_st
    logic [NUM_W-1:0] an, bn;
    logic [R_W-1:0] arn, brn;
    always_comb begin
      logic [R_W:0] t;
      an = na[g];
      bn = nb[g];
      arn = ra[g];
      brn = rb[g];
      for (int k = 0; k < DV_PER; k++) begin
        if (g * DV_PER + k < NDIV) begin
          t = {arn, an[NUM_W-1]} - {2'b00, d[g]};
          if (!t[R_W]) begin
            arn = t[R_W-1:0];
            an = {an[NUM_W-2:0], 1'b1};
          end else begin
            arn = {arn[R_W-2:0], an[NUM_W-1]};
            an = {an[NUM_W-2:0], 1'b0};
          end
          t = {brn, bn[NUM_W-1]} - {2'b00, d[g]};
          if (!t[R_W]) begin
            brn = t[R_W-1:0];
            bn = {bn[NUM_W-2:0], 1'b1};
          end else begin
            brn = {brn[R_W-2:0], bn[NUM_W-1]};
            bn = {bn[NUM_W-2:0], 1'b0};
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        na[g+1] <= an;
        nb[g+1] <= bn;
        ra[g+1] <= arn;
        rb[g+1] <= brn;
        d[g+1] <= d[g];
        c[g+1] <= c[g];
        sgx[g+1] <= sgx[g];
        sgy[g+1] <= sgy[g];
      end
    end
  end

  // round: bump when twice the remainder reaches the divisor
  always_comb begin
    logic [Q_W:0] qa, qb;
    qa = {1'b0, na[NDV_ST]} +
         (Q_W + 1)'({ra[NDV_ST], 1'b0} >= {2'b00, d[NDV_ST]});
    qb = {1'b0, nb[NDV_ST]} +
         (Q_W + 1)'({rb[NDV_ST], 1'b0} >= {2'b00, d[NDV_ST]});
    sxo = sgx[NDV_ST];
    syo = sgy[NDV_ST];
    wx = sxo ? -$signed(qa) : $signed(qa);
    wy = syo ? -$signed(qb) : $signed(qb);
  end
  assign ctl_out = c[NDV_ST];
endmodule

// File: rtl/local_zenith_frame_basis.sv
// top level: local north, west and up unit vectors from a sun-frame direction
//
// input channel: in_valid/in_ready with dir_x, dir_y, dir_z and slots_given.
// output channel: out_valid/out_ready with ok and the nine vector components.
// one result transaction follows each input transaction, in order.
// the pipeline takes one transaction per cycle while the output is not
// stalled; its stages are one radicand stage, NSQ_ST root stages, NDV_ST
// divider stages, one product stage and one output stage.
// the depth is set by the digit-per-stage square root and divider.
// the whole pipeline advances only when its last stage is empty or taken,
// so a receiver stall holds every stage in place and nothing is lost.
// reset clears all valid bits; no transaction is in flight afterward.
// a slot count other than three gives ok low and all components zero;
// near the sun axis the fixed basis is returned, negated for negative z.
module local_zenith_frame_basis (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [17:0] dir_x,
  input  logic signed [17:0] dir_y,
  input  logic signed [17:0] dir_z,
  input  logic [3:0] slots_given,
  output logic out_valid,
  input  logic out_ready,
  output logic ok,
  output logic signed [17:0] north_x,
  output logic signed [17:0] north_y,
  output logic signed [17:0] north_z,
  output logic signed [17:0] west_x,
  output logic signed [17:0] west_y,
  output logic signed [17:0] west_z,
  output logic signed [17:0] up_x,
  output logic signed [17:0] up_y,
  output logic signed [17:0] up_z
);
  import lzfb_pkg::*;
  localparam int DEPTH = 1 + NSQ_ST + NDV_ST + 2;

  logic en;
  logic [DEPTH-1:0] vld;
  assign en = !out_valid || out_ready;
  assign in_ready = en;
  assign out_valid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end

  // radicand stage
  logic [RAD_W-1:0] rad;
  ctl_t c0;
  always_ff @(posedge clk) begin
    if (en) begin
      logic [2*W-1:0] z2;
      logic [RAD_W-1:0] r;
      z2 = dir_z * dir_z;
      r = (ONE2 > RAD_W'(z2)) ? ONE2 - RAD_W'(z2) : '0;
      rad <= r;
      c0.ok <= slots_given == SLOTS_OK;
      c0.axis <= r < THR;
      c0.zneg <= dir_z[W-1];
      c0.x <= dir_x;
      c0.y <= dir_y;
      c0.z <= dir_z;
    end
  end

  logic [S_W-1:0] root;
  ctl_t c1, c2;
  lzfb_sqrt u_sqrt (.clk, .en, .rad, .ctl_in(c0), .root, .ctl_out(c1));

  logic [S_W-1:0] den;
  assign den = c1.axis ? S_W'(1) : root;
  logic signed [Q_W:0] wx, wy;
  lzfb_div u_div (.clk, .en, .den, .ctl_in(c1), .wx, .wy, .ctl_out(c2));

  // product stage
  logic signed [63:0] p0, p1, p2a, p2b;
  logic signed [Q_W:0] wx3, wy3;
  ctl_t c3;
  always_ff @(posedge clk) begin
    if (en) begin
      p0 <= 64'(wy) * 64'(c2.z);
      p1 <= -(64'(wx) * 64'(c2.z));
      p2a <= 64'(wx) * 64'(c2.y);
      p2b <= 64'(wy) * 64'(c2.x);
      wx3 <= wx;
      wy3 <= wy;
      c3 <= c2;
    end
  end

  // output stage
  always_ff @(posedge clk) begin
    if (en) begin
      ok <= c3.ok;
      west_z <= '0;
      if (c3.ok && c3.axis) begin
        north_x <= c3.zneg ? comp_t'(ONE) : -comp_t'(ONE);
        north_y <= '0;
        north_z <= '0;
        west_x <= '0;
        west_y <= c3.zneg ? comp_t'(ONE) : -comp_t'(ONE);
        up_x <= '0;
        up_y <= '0;
        up_z <= c3.zneg ? -comp_t'(ONE) : comp_t'(ONE);
      end else if (c3.ok) begin
        north_x <= sat(rnd_sh(p0));
        north_y <= sat(rnd_sh(p1));
        north_z <= sat(rnd_sh(p2a - p2b));
        west_x <= sat(64'(wx3));
        west_y <= sat(64'(wy3));
        up_x <= c3.x;
        up_y <= c3.y;
        up_z <= c3.z;
      end else begin
        north_x <= '0;
        north_y <= '0;
        north_z <= '0;
        west_x <= '0;
        west_y <= '0;
        up_x <= '0;
        up_y <= '0;
        up_z <= '0;
      end
    end
  end
endmodule

// File: rtl/lzfb_checker.sv
// port-level checker bound to the top level
module lzfb_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic ok,
  input logic signed [17:0] north_x,
  input logic signed [17:0] west_z,
  input logic signed [17:0] up_z
);
  a_rst: assert property (@(posedge clk) rst |=> !out_valid) else $error("valid after reset");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(up_z)) else $error("stalled result changed");
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready) else $error("accepted while stalled");
  a_wz: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> west_z == 18'sd0) else $error("west z nonzero");
  a_bad: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> north_x == 18'sd0 && up_z == 18'sd0) else $error("bad slot result");
endmodule

bind local_zenith_frame_basis lzfb_checker u_chk (.clk, .rst, .in_valid, .in_ready,
  .out_valid, .out_ready, .ok, .north_x, .west_z, .up_z);
